// ===== rtl/core/fifo_queue_with_key_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key-search queue
// Shared property wrappers used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_MACROS_SVH

// Checked only while reset is released.
`define FQKS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FQKS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fqks_pkg.sv =====
// ----------------------------------------------------------------------------
// Key-search queue package
// Operation codes, control state and the per-cell control bundle.
// ----------------------------------------------------------------------------
package fqks_pkg;

    localparam int OPCODE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FIND  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic write;   // load the pushed entry into this cell
        logic shift;   // take the entry of the next cell toward the rear
        logic search;  // register the key compare result
    } cell_ctrl_t;

endpackage

// ===== rtl/core/fqks_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry, hands it to the neighbor toward the front on a pop, and
// registers its own key compare for the search.
// ----------------------------------------------------------------------------
module fqks_cell #(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                     clk,
    input  fqks_pkg::cell_ctrl_t     ctrl,
    input  logic                     occupied,
    input  logic [KEY_WIDTH-1:0]     in_key,
    input  logic [PAYLOAD_WIDTH-1:0] in_payload,
    input  logic [KEY_WIDTH-1:0]     next_key,
    input  logic [PAYLOAD_WIDTH-1:0] next_payload,
    input  logic [KEY_WIDTH-1:0]     search_key,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] payload,
    output logic                     match
);

    logic [KEY_WIDTH-1:0]     key_reg;
    logic [KEY_WIDTH-1:0]     key_next;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_next;
    logic                     match_reg;
    logic                     match_next;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.write)
        begin
            key_next     = in_key;
            payload_next = in_payload;
        end
        else if (ctrl.shift)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
        match_next = ctrl.search ? (occupied && (key_reg == search_key)) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        match_reg   <= match_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign match   = match_reg;

endmodule

// ===== rtl/core/fqks_locate.sv =====
// ----------------------------------------------------------------------------
// Match locator
// Turns the row of cell match flags into the 1-based position of the first
// match, counted from the front cell.
// ----------------------------------------------------------------------------
module fqks_locate #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]               match_flags,
    output logic                           found,
    output logic [$clog2(DEPTH+1)-1:0]     position
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] lowest;
    logic [IW-1:0]    index;

    // Isolating the lowest set flag leaves a one-hot vector, so the index is
    // an OR over the set position.
    always_comb
    begin
        lowest = match_flags & (~match_flags + {{(DEPTH-1){1'b0}}, 1'b1});
        index  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (lowest[i])
            begin
                index = index | IW'(i);
            end
        end
    end

    assign found    = |match_flags;
    assign position = CW'(index) + CW'(1);

endmodule

// ===== rtl/core/fifo_queue_with_key_search.sv =====
// ----------------------------------------------------------------------------
// Key-search queue
// Bounded FIFO of key and payload entries with push, pop, peek, find and clear.
// ----------------------------------------------------------------------------
// Each request is accepted in S_IDLE and executed in S_EXEC. In the cycle it
// is accepted every cell compares its key with entry_key and registers the
// result; in S_EXEC the locator picks the first match, the cell row is
// updated (a push writes the cell at the fill count, a pop moves every entry
// one cell toward the front) and the result is loaded into the output
// register. The next request is accepted in the cycle after that, so no new
// request is taken before the last one has executed; a result left waiting
// holds the block in S_EXEC until out_ready rises.
`include "fifo_queue_with_key_search_macros.svh"

module fifo_queue_with_key_search #(
    parameter int DEPTH         = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fqks_pkg::OPCODE_W-1:0]     opcode,
    input  logic [KEY_WIDTH-1:0]              entry_key,
    input  logic [PAYLOAD_WIDTH-1:0]          entry_payload,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic [KEY_WIDTH-1:0]              out_key,
    output logic [PAYLOAD_WIDTH-1:0]          out_payload,
    output logic [$clog2(DEPTH+1)-1:0]        found_position,
    output logic [$clog2(DEPTH+1)-1:0]        entry_count,
    output logic                              is_empty
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    fqks_pkg::state_t state_reg;
    fqks_pkg::state_t state_next;

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [fqks_pkg::OPCODE_W-1:0] op_reg;
    logic [KEY_WIDTH-1:0]          key_reg;
    logic [PAYLOAD_WIDTH-1:0]      payload_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     ok_reg;
    logic                     ok_next;
    logic [KEY_WIDTH-1:0]     out_key_reg;
    logic [KEY_WIDTH-1:0]     out_key_next;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg;
    logic [PAYLOAD_WIDTH-1:0] out_payload_next;
    logic [CW-1:0]            found_position_reg;
    logic [CW-1:0]            found_position_next;

    logic accept;
    logic fire;
    logic do_push;
    logic do_pop;

    logic [KEY_WIDTH-1:0]     cell_key [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] cell_payload [DEPTH];
    logic [DEPTH-1:0]         cell_match;

    logic          hit;
    logic [CW-1:0] hit_position;

    assign in_ready = (state_reg == fqks_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == fqks_pkg::S_EXEC) && (!out_valid_reg || out_ready);
    assign do_push  = fire && (op_reg == fqks_pkg::OP_PUSH) && (count_reg != FULL_COUNT);
    assign do_pop   = fire && (op_reg == fqks_pkg::OP_POP) && (count_reg != '0);

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] SLOT = CW'(i);

            fqks_pkg::cell_ctrl_t     ctrl;
            logic [KEY_WIDTH-1:0]     nb_key;
            logic [PAYLOAD_WIDTH-1:0] nb_payload;

            assign ctrl.write  = do_push && (count_reg == SLOT);
            assign ctrl.shift  = do_pop;
            assign ctrl.search = accept;

            if (i == DEPTH - 1)
            begin : g_last
                assign nb_key     = cell_key[i];
                assign nb_payload = cell_payload[i];
            end
            else
            begin : g_inner
                assign nb_key     = cell_key[i+1];
                assign nb_payload = cell_payload[i+1];
            end

            fqks_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .occupied     (SLOT < count_reg),
                .in_key       (key_reg),
                .in_payload   (payload_reg),
                .next_key     (nb_key),
                .next_payload (nb_payload),
                .search_key   (entry_key),
                .key          (cell_key[i]),
                .payload      (cell_payload[i]),
                .match        (cell_match[i])
            );
        end
    endgenerate

    fqks_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .match_flags (cell_match),
        .found       (hit),
        .position    (hit_position)
    );

    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        ok_next             = ok_reg;
        out_key_next        = out_key_reg;
        out_payload_next    = out_payload_reg;
        found_position_next = found_position_reg;

        unique case (state_reg)
            fqks_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = fqks_pkg::S_EXEC;
                end
            end
            fqks_pkg::S_EXEC:
            begin
                if (fire)
                begin
                    state_next          = fqks_pkg::S_IDLE;
                    out_valid_next      = 1'b1;
                    ok_next             = 1'b0;
                    out_key_next        = '0;
                    out_payload_next    = '0;
                    found_position_next = '0;
                    unique case (op_reg)
                        fqks_pkg::OP_PUSH:
                        begin
                            if (count_reg != FULL_COUNT)
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fqks_pkg::OP_POP, fqks_pkg::OP_PEEK:
                        begin
                            if (count_reg != '0)
                            begin
                                ok_next          = 1'b1;
                                out_key_next     = cell_key[0];
                                out_payload_next = cell_payload[0];
                                if (op_reg == fqks_pkg::OP_POP)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                            end
                        end
                        fqks_pkg::OP_FIND:
                        begin
                            ok_next = hit;
                            if (hit)
                            begin
                                found_position_next = hit_position;
                            end
                        end
                        fqks_pkg::OP_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = fqks_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqks_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            key_reg     <= entry_key;
            payload_reg <= entry_payload;
        end
        ok_reg             <= ok_next;
        out_key_reg        <= out_key_next;
        out_payload_reg    <= out_payload_next;
        found_position_reg <= found_position_next;
    end

    // The count register already holds the count after the operation when
    // the result is loaded, so the count fields come straight from it.
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign out_key        = out_key_reg;
    assign out_payload    = out_payload_reg;
    assign found_position = found_position_reg;
    assign entry_count    = count_reg;
    assign is_empty       = (count_reg == '0);

    `FQKS_ASSERT_ALWAYS(a_count_bounded, clk, (!rst_n) || (count_reg <= FULL_COUNT),
        "count above depth")
    `FQKS_ASSERT(a_accept_to_exec, clk, rst_n, accept |=> (state_reg == fqks_pkg::S_EXEC),
        "accepted request did not enter execution")
    `FQKS_ASSERT(a_pop_decrements, clk, rst_n,
        do_pop |=> (count_reg == $past(count_reg) - CW'(1)), "pop did not decrement count")
    `FQKS_ASSERT(a_position_needs_ok, clk, rst_n,
        out_valid_reg |-> (found_position_reg == '0 || ok_reg),
        "position reported without success")

endmodule
